// ===== design/alccs_pkg.sv =====
// Package with types, constants and helper functions for the arc-length cubic curve sampler.
package alccs_pkg;

   localparam int TableSizeDefault = 256;
   localparam int NumCoeffs = 12;
   localparam logic [16:0] OneU = 17'h10000;

   localparam logic [1:0] OpLoad   = 2'd0;
   localparam logic [1:0] OpBuild  = 2'd1;
   localparam logic [1:0] OpQuery  = 2'd2;
   localparam logic [1:0] OpUnused = 2'd3;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusNotBuilt = 2'd1;
   localparam logic [1:0] StatusTooShort = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EVAL_RD,
      ST_EVAL_MUL,
      ST_EVAL_ADD,
      ST_EVAL_SAT,
      ST_SEG_SQ,
      ST_SEG_SUM,
      ST_SQRT,
      ST_CUM_WR,
      ST_NORM,
      ST_SCL_RD,
      ST_SCL_MUL,
      ST_DIV,
      ST_SCL_WR,
      ST_Q_RD,
      ST_Q_CMP,
      ST_Q_LO,
      ST_Q_MUL,
      ST_Q_DIVDONE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      EV_BUILD,
      EV_QUERY
   } eval_mode_type;

   // Floor shift by 16 of a signed 64-bit value.
   function automatic logic signed [63:0] shr16(input logic signed [63:0] v);
      shr16 = v >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

// ===== design/arc_length_cubic_curve_sampler.sv =====
// Top level of the arc-length cubic curve sampler: coefficient store, arc table and sequencer.
//
//   channel | direction | handshake        | payload
//   req     | in        | tvalid/tready    | tdata {path_position, coeff_value, coeff_index, opcode}
//   rsp     | out       | tvalid/tready    | tdata {pos_z, pos_y, pos_x, param_u}, tuser status
//   csr     | in        | wen              | wdata curve_length
//
// The time of a query is set by the linear table scan, the 64-step serial divider and three
// axis evaluations. The time of a build is set, for each table entry, by the shared axis
// evaluator, the 32-step square root and the divider. One transaction is worked on at a time;
// req_tready is low until its result is taken. Reset is synchronous; after it the coefficient
// store is cleared slot by slot with req_tready low. The arc table is not cleared and is only
// read after a build. A stalled rsp channel holds its result in the output register.
module arc_length_cubic_curve_sampler
   import alccs_pkg::*;
#(
   parameter int TABLE_SIZE = TableSizeDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0], coeff_index[5:2], coeff_value[37:6], path_position[69:38], zero fill
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // param_u[16:0], pos_x[48:17], pos_y[80:49], pos_z[112:81], zero fill
   output logic [119:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_wen,
   input  logic [31:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 1);
   localparam logic [CW-1:0] LastIdx = CW'(TABLE_SIZE - 1);
   // Rounded-up reciprocal of TABLE_SIZE-1 scaled by 2^40; exact for every table index.
   localparam logic [63:0] RecipU =
      ((64'd1 << 40) + 64'(TABLE_SIZE - 2)) / 64'(TABLE_SIZE - 1);

   state_type state_ff, state_in;

   logic [31:0] curve_length_ff;
   logic        table_ready_ff, table_ready_in;

   // Coefficient store: synchronous memory with a registered read.
   logic signed [31:0] coeff_mem [NumCoeffs];
   logic [3:0]         coeff_raddr;
   logic signed [31:0] coeff_rdata_ff;
   logic               coeff_we;
   logic [3:0]         coeff_waddr;
   logic signed [31:0] coeff_wdata;

   // Arc table: synchronous memory holding cumulative then scaled lengths.
   logic [63:0]   arc_mem [TABLE_SIZE];
   logic [AW-1:0] arc_raddr;
   logic [63:0]   arc_rdata_ff;
   logic          arc_we;
   logic [AW-1:0] arc_waddr;
   logic [63:0]   arc_wdata;

   // Sequencer registers.
   eval_mode_type mode_ff, mode_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [1:0]    axis_ff, axis_in;
   logic [1:0]    pow_ff, pow_in;
   logic [16:0]   u_ff, u_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] pt_ff [3];
   logic signed [31:0] pt_in [3];
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] prev_in [3];
   logic [63:0]   sq_ff [3];
   logic [63:0]   sq_in [3];
   logic [63:0]   sum_ff, sum_in;
   logic [63:0]   res_ff, res_in;
   logic [63:0]   bit_ff, bit_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [63:0]   total_ff, total_in;
   logic [5:0]    k_ff, k_in;
   logic [63:0]   lo_ff, lo_in;
   logic [31:0]   s_ff, s_in;
   logic [16:0]   u0_ff, u0_in;

   // Serial restoring divider, 64-bit quotient, 32-bit divisor.
   logic [63:0] dnum_ff, dnum_in;
   logic [32:0] drem_ff, drem_in;
   logic [31:0] dden_ff, dden_in;
   logic [6:0]  dcnt_ff, dcnt_in;

   // Output register.
   logic         ovalid_ff, ovalid_in;
   logic [1:0]   ostat_ff, ostat_in;
   logic [16:0]  ou_ff, ou_in;
   logic signed [31:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;

   logic [3:0] clr_ff;
   logic       clr_busy;

   logic req_acc;
   assign req_tready = (state_ff == ST_IDLE) && !ovalid_ff && !clr_busy;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = ostat_ff;
   assign rsp_tdata  = {7'd0, oz_ff, oy_ff, ox_ff, ou_ff};

   // u_i = floor(i * 65536 / (TABLE_SIZE-1)) by a multiplication with the scaled reciprocal.
   function automatic logic [16:0] sample_u(input logic [CW-1:0] i);
      sample_u = 17'((64'(i) * RecipU) >> 24);
   endfunction

   always_ff @(posedge clock) begin
      if (coeff_we) begin
         coeff_mem[coeff_waddr] <= coeff_wdata;
      end
      coeff_rdata_ff <= coeff_mem[coeff_raddr];
      if (arc_we) begin
         arc_mem[arc_waddr] <= arc_wdata;
      end
      arc_rdata_ff <= arc_mem[arc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         curve_length_ff <= '0;
         table_ready_ff  <= 1'b0;
         ovalid_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         table_ready_ff <= table_ready_in;
         ovalid_ff      <= ovalid_in;
         if (csr_wen) begin
            curve_length_ff <= csr_wdata;
         end
      end
   end

   // After reset the coefficient store is cleared one slot per cycle through its write port;
   // requests wait until the pass ends.
   assign clr_busy = (clr_ff != 4'(NumCoeffs));
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clr_busy) begin
         clr_ff <= clr_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      idx_ff   <= idx_in;
      axis_ff  <= axis_in;
      pow_ff   <= pow_in;
      u_ff     <= u_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      pt_ff    <= pt_in;
      prev_ff  <= prev_in;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      cnt_ff   <= cnt_in;
      total_ff <= total_in;
      k_ff     <= k_in;
      lo_ff    <= lo_in;
      s_ff     <= s_in;
      u0_ff    <= u0_in;
      dnum_ff  <= dnum_in;
      drem_ff  <= drem_in;
      dden_ff  <= dden_in;
      dcnt_ff  <= dcnt_in;
      ostat_ff <= ostat_in;
      ou_ff    <= ou_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      oz_ff    <= oz_in;
   end

   logic signed [63:0] dsx;
   logic [63:0]        mag;
   logic [32:0]        dtrial;
   logic [63:0]        rb;
   logic [31:0]        arc_lo32;
   logic signed [52:0] hprod;

   always_comb begin
      state_in       = state_ff;
      table_ready_in = table_ready_ff;
      ovalid_in      = ovalid_ff && !rsp_tready;
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      axis_in  = axis_ff;
      pow_in   = pow_ff;
      u_in     = u_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      pt_in    = pt_ff;
      prev_in  = prev_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      k_in     = k_ff;
      lo_in    = lo_ff;
      s_in     = s_ff;
      u0_in    = u0_ff;
      dnum_in  = dnum_ff;
      drem_in  = drem_ff;
      dden_in  = dden_ff;
      dcnt_in  = dcnt_ff;
      ostat_in = ostat_ff;
      ou_in    = ou_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oz_in    = oz_ff;
      coeff_raddr = {axis_ff, pow_ff};
      coeff_we    = clr_busy;
      coeff_waddr = clr_ff;
      coeff_wdata = '0;
      arc_raddr = idx_ff[AW-1:0];
      arc_we    = 1'b0;
      arc_waddr = idx_ff[AW-1:0];
      arc_wdata = '0;
      dsx    = '0;
      mag    = '0;
      rb     = '0;
      hprod  = '0;
      arc_lo32 = arc_rdata_ff[31:0];
      dtrial = {drem_ff[31:0], dnum_ff[63]} - {1'b0, dden_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ostat_in = StatusOk;
               ou_in = '0;
               ox_in = '0;
               oy_in = '0;
               oz_in = '0;
               state_in = ST_OUT;
               case (req_tdata[1:0])
                  OpLoad: begin
                     if (req_tdata[5:2] < 4'(NumCoeffs) && !clr_busy) begin
                        coeff_we    = 1'b1;
                        coeff_waddr = req_tdata[5:2];
                        coeff_wdata = req_tdata[37:6];
                     end
                  end
                  OpBuild: begin
                     if (curve_length_ff == '0) begin
                        table_ready_in = 1'b0;
                        ostat_in = StatusTooShort;
                     end else begin
                        mode_in  = EV_BUILD;
                        idx_in   = '0;
                        u_in     = '0;
                        axis_in  = 2'd0;
                        pow_in   = 2'd3;
                        total_in = '0;
                        state_in = ST_EVAL_RD;
                     end
                  end
                  OpQuery: begin
                     if (!table_ready_ff) begin
                        ostat_in = StatusNotBuilt;
                     end else if (curve_length_ff == '0) begin
                        ostat_in = StatusTooShort;
                        mode_in  = EV_QUERY;
                        u_in     = '0;
                        axis_in  = 2'd0;
                        pow_in   = 2'd3;
                        state_in = ST_EVAL_RD;
                     end else begin
                        s_in = (req_tdata[69:38] > curve_length_ff) ?
                               curve_length_ff : req_tdata[69:38];
                        idx_in   = '0;
                        state_in = ST_Q_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Horner evaluation of one axis: the coefficient memory is read one power at a time.
         ST_EVAL_RD: begin
            coeff_raddr = {axis_ff, pow_ff};
            state_in = ST_EVAL_ADD;
         end
         ST_EVAL_ADD: begin
            if (pow_ff == 2'd3) begin
               acc_in = 64'(coeff_rdata_ff);
            end else begin
               acc_in = shr16(prod_ff) + 64'(coeff_rdata_ff);
            end
            state_in = (pow_ff == 2'd0) ? ST_EVAL_SAT : ST_EVAL_MUL;
         end
         ST_EVAL_MUL: begin
            // The accumulator stays within 35 signed bits, so a 35 by 18 product is enough.
            hprod   = 53'(signed'(acc_ff[34:0])) * 53'(signed'({1'b0, u_ff}));
            prod_in = 64'(hprod);
            pow_in  = pow_ff - 2'd1;
            state_in = ST_EVAL_RD;
         end
         ST_EVAL_SAT: begin
            pt_in[axis_ff] = sat32(acc_ff);
            pow_in = 2'd3;
            if (axis_ff != 2'd2) begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_EVAL_RD;
            end else begin
               axis_in = 2'd0;
               if (mode_ff == EV_QUERY) begin
                  ox_in = pt_in[0];
                  oy_in = pt_in[1];
                  oz_in = pt_in[2];
                  ou_in = u_ff;
                  state_in = ST_OUT;
               end else if (idx_ff == '0) begin
                  prev_in  = pt_in;
                  arc_we   = 1'b1;
                  arc_waddr = '0;
                  arc_wdata = '0;
                  idx_in   = CW'(1);
                  u_in     = sample_u(CW'(1));
                  state_in = ST_EVAL_RD;
               end else begin
                  state_in = ST_SEG_SQ;
               end
            end
         end
         ST_SEG_SQ: begin
            for (int a = 0; a < 3; a++) begin
               dsx = 64'(pt_ff[a]) - 64'(prev_ff[a]);
               mag = dsx[63] ? 64'(-dsx) : 64'(dsx);
               if (mag > 64'h7FFF_FFFF) begin
                  mag = 64'h7FFF_FFFF;
               end
               sq_in[a] = 64'(mag[30:0]) * 64'(mag[30:0]);
            end
            state_in = ST_SEG_SUM;
         end
         ST_SEG_SUM: begin
            sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
            res_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
            cnt_in = '0;
            prev_in = pt_ff;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            rb = res_ff + bit_ff;
            if (sum_ff >= rb) begin
               sum_in = sum_ff - rb;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = ST_CUM_WR;
            end
         end
         ST_CUM_WR: begin
            total_in  = total_ff + res_ff;
            arc_we    = 1'b1;
            arc_wdata = total_ff + res_ff;
            if (idx_ff == LastIdx) begin
               k_in = '0;
               state_in = ST_NORM;
            end else begin
               idx_in = idx_ff + CW'(1);
               u_in   = sample_u(idx_ff + CW'(1));
               state_in = ST_EVAL_RD;
            end
         end
         ST_NORM: begin
            if ((total_ff >> k_ff) > 64'hFFFF_FFFF) begin
               k_in = k_ff + 6'd1;
            end else begin
               total_in = total_ff >> k_ff;
               idx_in = '0;
               state_in = ST_SCL_RD;
            end
         end
         ST_SCL_RD: begin
            state_in = ST_SCL_MUL;
         end
         ST_SCL_MUL: begin
            lo_in   = (arc_rdata_ff >> k_ff);
            dnum_in = 64'(lo_in[31:0]) * 64'(curve_length_ff);
            dden_in = total_ff[31:0];
            drem_in = '0;
            dcnt_in = '0;
            state_in = (total_ff == '0) ? ST_SCL_WR : ST_DIV;
            if (total_ff == '0) begin
               dnum_in = '0;
            end
         end
         // One quotient bit a cycle; the quotient shifts into dnum.
         ST_DIV: begin
            if (!dtrial[32]) begin
               drem_in = dtrial;
               dnum_in = {dnum_ff[62:0], 1'b1};
            end else begin
               drem_in = {drem_ff[31:0], dnum_ff[63]};
               dnum_in = {dnum_ff[62:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'd63) begin
               state_in = (mode_ff == EV_BUILD) ? ST_SCL_WR : ST_Q_DIVDONE;
            end
         end
         ST_SCL_WR: begin
            arc_we = 1'b1;
            arc_wdata = (idx_ff == LastIdx) ? 64'(curve_length_ff) : 64'(dnum_ff[31:0]);
            if (idx_ff == LastIdx) begin
               table_ready_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_SCL_RD;
            end
         end

         // Linear scan for the first entry at or above the clamped position.
         ST_Q_RD: begin
            state_in = ST_Q_CMP;
         end
         ST_Q_CMP: begin
            if (arc_lo32 >= s_ff) begin
               if (idx_ff == '0) begin
                  u_in = '0;
                  mode_in = EV_QUERY;
                  axis_in = 2'd0;
                  pow_in = 2'd3;
                  state_in = ST_EVAL_RD;
               end else begin
                  lo_in = 64'(arc_lo32);
                  idx_in = idx_ff - CW'(1);
                  state_in = ST_Q_LO;
               end
            end else if (idx_ff == LastIdx) begin
               u_in = OneU;
               mode_in = EV_QUERY;
               axis_in = 2'd0;
               pow_in = 2'd3;
               state_in = ST_EVAL_RD;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_Q_RD;
            end
         end
         ST_Q_LO: begin
            // Read of entry i-1 is in flight; the grid parameters of both ends are set up.
            u0_in = sample_u(idx_ff);
            u_in  = sample_u(idx_ff + CW'(1));
            state_in = ST_Q_MUL;
            if (cnt_ff != 6'd1) begin
               cnt_in = 6'd1;
               state_in = ST_Q_LO;
            end
         end
         ST_Q_MUL: begin
            cnt_in = '0;
            if (lo_ff[31:0] <= arc_lo32) begin
               u_in = u0_ff;
               mode_in = EV_QUERY;
               axis_in = 2'd0;
               pow_in = 2'd3;
               state_in = ST_EVAL_RD;
            end else begin
               dnum_in = 64'(s_ff - arc_lo32) * 64'(u_ff - u0_ff);
               dden_in = lo_ff[31:0] - arc_lo32;
               drem_in = '0;
               dcnt_in = '0;
               mode_in = EV_QUERY;
               state_in = ST_DIV;
            end
         end
         ST_Q_DIVDONE: begin
            u_in = u0_ff + dnum_ff[16:0];
            axis_in = 2'd0;
            pow_in = 2'd3;
            state_in = ST_EVAL_RD;
         end

         ST_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Only one transaction is in flight, so the output register is never loaded while full.
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> !ovalid_ff)
      else $error("request accepted while a result is pending");

   a_out_from_out_state: assert property (@(posedge clock) disable iff (reset)
      $rose(ovalid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output state");

   a_ready_set_by_build: assert property (@(posedge clock) disable iff (reset)
      $rose(table_ready_ff) |-> $past(state_ff) == ST_SCL_WR)
      else $error("table marked ready outside the scaling pass");

endmodule
